// ----- rtl/pal_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

  localparam int DEPTH_DEF = 64;

  // Action codes
  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_SEARCH = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD       = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic [6:0]         position;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         found_position;
    logic signed [31:0] read_value;
    logic [6:0]         count;
  } out_rsp_t;

  // Read address source
  typedef enum logic [1:0] {
    RA_IDX     = 2'd0,
    RA_IDX_DEC = 2'd1,
    RA_IDX_INC = 2'd2,
    RA_P0      = 2'd3
  } rd_addr_t;

  typedef struct packed {
    logic       load_req;
    logic       idx_ld_count;
    logic       idx_ld_p0;
    logic       idx_ld_zero;
    logic       idx_inc;
    logic       idx_dec;
    logic       ram_rd;
    rd_addr_t   rd_sel;
    logic       ram_wr;
    logic       wr_val;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       st_ld;
    logic [2:0] st_code;
    logic       cap_found;
    logic       cap_rd;
    logic       out_ld;
  } pal_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       full;
    logic       empty;
    logic       ins_pos_ok;
    logic       pos_ok;
    logic       ins_done;
    logic       del_done;
    logic       srch_end;
    logic       match;
  } pal_sts_t;

endpackage

`default_nettype wire

// ----- rtl/pal_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pal_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pal_datapath #(
  parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pal_pkg::in_req_t  in_req,
  input  wire pal_pkg::pal_cmd_t cmd,
  output pal_pkg::pal_sts_t      sts,
  output pal_pkg::out_rsp_t      out_rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  pal_pkg::in_req_t  req_r;
  pal_pkg::out_rsp_t out_rsp_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     idx_r;
  logic [2:0]        status_r;
  logic [6:0]        found_r;
  logic [31:0]       rd_r;

  logic [XW:0]       pos_w;
  logic [XW:0]       cnt_w;
  logic [XW:0]       idx_w;
  logic [XW:0]       p0_w;
  logic [XW-1:0]     idx_p1;
  logic [XW-1:0]     cnt_x;
  logic [CW-1:0]     idx_m1;
  logic [CW-1:0]     idx_pl;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [31:0]       ram_wr_data;
  logic [AW-1:0]     ram_rd_addr;
  logic [31:0]       ram_rd_data;

  assign pos_w  = (XW + 1)'(req_r.position);
  assign cnt_w  = (XW + 1)'(count_r);
  assign idx_w  = (XW + 1)'(idx_r);
  assign p0_w   = pos_w - (XW + 1)'(1);
  assign idx_m1 = idx_r - CW'(1);
  assign idx_pl = idx_r + CW'(1);
  assign idx_p1 = XW'(idx_r) + XW'(1);
  assign cnt_x  = XW'(count_r);

  always_comb begin
    sts.action     = req_r.action;
    sts.full       = (count_r == CW'(DEPTH));
    sts.empty      = (count_r == '0);
    sts.ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + (XW + 1)'(1));
    sts.pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
    sts.ins_done   = (idx_w == p0_w);
    sts.del_done   = (idx_w + (XW + 1)'(1) == cnt_w);
    sts.srch_end   = (idx_r == count_r);
    sts.match      = (ram_rd_data == 32'(req_r.value));
  end

  always_comb begin
    case (cmd.rd_sel)
      pal_pkg::RA_IDX_DEC: ram_rd_addr = idx_m1[AW-1:0];
      pal_pkg::RA_IDX_INC: ram_rd_addr = idx_pl[AW-1:0];
      pal_pkg::RA_P0:      ram_rd_addr = p0_w[AW-1:0];
      default:             ram_rd_addr = idx_r[AW-1:0];
    endcase
  end

  assign ram_wr_en   = cmd.ram_wr;
  assign ram_wr_addr = cmd.wr_val ? p0_w[AW-1:0] : idx_r[AW-1:0];
  assign ram_wr_data = cmd.wr_val ? 32'(req_r.value) : ram_rd_data;

  pal_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.ram_rd),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_clr) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r    <= in_req;
      found_r  <= '0;
      rd_r     <= '0;
      status_r <= pal_pkg::ST_OK;
    end else begin
      if (cmd.st_ld) begin
        status_r <= cmd.st_code;
      end
      if (cmd.cap_found) begin
        found_r <= idx_p1[6:0];
      end
      if (cmd.cap_rd) begin
        rd_r <= ram_rd_data;
      end
    end

    if (cmd.idx_ld_count) begin
      idx_r <= count_r;
    end else if (cmd.idx_ld_p0) begin
      idx_r <= CW'(p0_w);
    end else if (cmd.idx_ld_zero) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_pl;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_m1;
    end

    if (cmd.out_ld) begin
      out_rsp_r.status         <= status_r;
      out_rsp_r.found_position <= found_r;
      out_rsp_r.read_value     <= $signed(rd_r);
      out_rsp_r.count          <= cnt_x[6:0];
    end
  end

  assign out_rsp = out_rsp_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (count_r < CW'(DEPTH)) && cmd.ram_wr && cmd.wr_val)
    else $error("count grows without the new word written");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> count_r != '0)
    else $error("count shrinks below zero");

endmodule

`default_nettype wire

// ----- rtl/pal_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pal_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire pal_pkg::pal_sts_t sts,
  output pal_pkg::pal_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_SR_RD,
    S_SR_CMP,
    S_RD_CAP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.rd_sel  = pal_pkg::RA_IDX;
    in_ready    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        cmd.st_ld = 1'b1;
        state_nxt = S_DONE;
        unique case (sts.action)
          pal_pkg::ACT_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.st_code = pal_pkg::ST_OK;
          end
          pal_pkg::ACT_INSERT: begin
            if (sts.full) begin
              cmd.st_code = pal_pkg::ST_FULL;
            end else if (!sts.ins_pos_ok) begin
              cmd.st_code = pal_pkg::ST_BAD;
            end else begin
              cmd.st_code      = pal_pkg::ST_OK;
              cmd.idx_ld_count = 1'b1;
              state_nxt        = S_INS_RD;
            end
          end
          pal_pkg::ACT_DELETE: begin
            if (sts.empty) begin
              cmd.st_code = pal_pkg::ST_EMPTY;
            end else if (!sts.pos_ok) begin
              cmd.st_code = pal_pkg::ST_BAD;
            end else begin
              cmd.st_code   = pal_pkg::ST_OK;
              cmd.idx_ld_p0 = 1'b1;
              state_nxt     = S_DEL_RD;
            end
          end
          pal_pkg::ACT_SEARCH: begin
            if (sts.empty) begin
              cmd.st_code = pal_pkg::ST_EMPTY;
            end else begin
              cmd.st_code     = pal_pkg::ST_NOT_FOUND;
              cmd.idx_ld_zero = 1'b1;
              state_nxt       = S_SR_RD;
            end
          end
          pal_pkg::ACT_READ: begin
            if (sts.empty) begin
              cmd.st_code = pal_pkg::ST_EMPTY;
            end else if (!sts.pos_ok) begin
              cmd.st_code = pal_pkg::ST_BAD;
            end else begin
              cmd.st_code = pal_pkg::ST_OK;
              cmd.ram_rd  = 1'b1;
              cmd.rd_sel  = pal_pkg::RA_P0;
              state_nxt   = S_RD_CAP;
            end
          end
          default: begin
            cmd.st_code = pal_pkg::ST_BAD;
          end
        endcase
      end
      S_INS_RD: begin
        if (sts.ins_done) begin
          // open slot reached: drop the new word in
          cmd.ram_wr  = 1'b1;
          cmd.wr_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.ram_rd = 1'b1;
          cmd.rd_sel = pal_pkg::RA_IDX_DEC;
          state_nxt  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.ram_wr  = 1'b1;
        cmd.idx_dec = 1'b1;
        state_nxt   = S_INS_RD;
      end
      S_DEL_RD: begin
        if (sts.del_done) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.ram_rd = 1'b1;
          cmd.rd_sel = pal_pkg::RA_IDX_INC;
          state_nxt  = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.ram_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_DEL_RD;
      end
      S_SR_RD: begin
        if (sts.srch_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ram_rd = 1'b1;
          cmd.rd_sel = pal_pkg::RA_IDX;
          state_nxt  = S_SR_CMP;
        end
      end
      S_SR_CMP: begin
        if (sts.match) begin
          cmd.st_ld     = 1'b1;
          cmd.st_code   = pal_pkg::ST_OK;
          cmd.cap_found = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SR_RD;
        end
      end
      S_RD_CAP: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DEC)
    else $error("accepted request not decoded next cycle");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("response raised outside completion");

  a_shift_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WR || state_r == S_DEL_WR) |-> $past(cmd.ram_rd))
    else $error("shift write without a preceding read");

endmodule

`default_nettype wire

// ----- rtl/positional_array_list.sv -----
// A request is accepted in idle and decoded; clear and rejected requests then
// complete, read fetches the addressed entry, insert shifts up from the end
// to the position, delete shifts down from it, search compares from entry one.
// One request at a time; the next is taken once the previous response is loaded.
// Every shift step goes through the single read port of the entry RAM.
// Reset (rst_n, synchronous) empties the list; entry storage is left as it was.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list #(
  parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pal_pkg::in_req_t in_req,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pal_pkg::out_rsp_t     out_rsp
);

  pal_pkg::pal_cmd_t cmd;
  pal_pkg::pal_sts_t sts;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pal_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_rsp (out_rsp)
  );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH       = pal_pkg::DEPTH_DEF;
  localparam int ITEMS_TOTAL = 780;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_AT     = 350;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 160;

  typedef struct {
    pal_pkg::in_req_t req;
    bit               drain;
  } queued_req_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  pal_pkg::in_req_t  in_req    = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pal_pkg::out_rsp_t out_rsp;

  positional_array_list #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow list and the responses it predicts
  logic signed [31:0] list_words [DEPTH];
  int                 list_len = 0;
  pal_pkg::out_rsp_t  pending_rsp [$];
  queued_req_t        req_backlog [$];

  int  accepted_n = 0;
  int  checked_n  = 0;
  int  errors     = 0;
  int  gap_left   = 0;
  int  stall_left = 0;
  bit  tx_burst   = 1'b0;
  bit  rx_burst   = 1'b0;
  bit  rx_hold    = 1'b0;
  bit  hold_done  = 1'b0;
  int  hold_cnt   = 0;
  int  cycle_n    = 0;

  // Generator side: only the list length is tracked, to aim positions
  int  gen_len = 0;
  int  gen_n   = 0;

  task automatic list_apply(input pal_pkg::in_req_t r);
    pal_pkg::out_rsp_t rsp;
    int                pos;
    int                i;
    rsp = '0;
    rsp.status = pal_pkg::ST_OK;
    pos = int'(r.position);
    case (r.action)
      pal_pkg::ACT_CLEAR: list_len = 0;
      pal_pkg::ACT_INSERT: begin
        if (list_len >= DEPTH) begin
          rsp.status = pal_pkg::ST_FULL;
        end else if (pos < 1 || pos > list_len + 1) begin
          rsp.status = pal_pkg::ST_BAD;
        end else begin
          for (i = list_len; i >= pos; i--) list_words[i] = list_words[i - 1];
          list_words[pos - 1] = r.value;
          list_len++;
        end
      end
      pal_pkg::ACT_DELETE: begin
        if (list_len == 0) begin
          rsp.status = pal_pkg::ST_EMPTY;
        end else if (pos < 1 || pos > list_len) begin
          rsp.status = pal_pkg::ST_BAD;
        end else begin
          for (i = pos - 1; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      pal_pkg::ACT_SEARCH: begin
        if (list_len == 0) begin
          rsp.status = pal_pkg::ST_EMPTY;
        end else begin
          rsp.status = pal_pkg::ST_NOT_FOUND;
          for (i = 0; i < list_len; i++) begin
            if (list_words[i] == r.value) begin
              rsp.status         = pal_pkg::ST_OK;
              rsp.found_position = 7'(i + 1);
              break;
            end
          end
        end
      end
      pal_pkg::ACT_READ: begin
        if (list_len == 0) begin
          rsp.status = pal_pkg::ST_EMPTY;
        end else if (pos < 1 || pos > list_len) begin
          rsp.status = pal_pkg::ST_BAD;
        end else begin
          rsp.read_value = list_words[pos - 1];
        end
      end
      default: rsp.status = pal_pkg::ST_BAD;
    endcase
    rsp.count = 7'(list_len);
    pending_rsp.push_back(rsp);
  endtask

  task automatic push_req(input logic [2:0] act, input int pos,
                          input logic signed [31:0] val, input bit drain);
    queued_req_t q;
    q.req.action   = act;
    q.req.position = 7'(pos);
    q.req.value    = val;
    q.drain        = drain;
    req_backlog.push_back(q);
    gen_n++;
    case (act)
      pal_pkg::ACT_CLEAR: gen_len = 0;
      pal_pkg::ACT_INSERT: if (gen_len < DEPTH && pos >= 1 && pos <= gen_len + 1) gen_len++;
      pal_pkg::ACT_DELETE: if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // Small values repeat often, so searches hit
  function automatic logic signed [31:0] pool_value();
    if ($urandom_range(0, 1) == 0) return 32'(int'($urandom_range(0, 15)) - 4);
    return $urandom;
  endfunction

  always @(posedge clk) begin : drive_requests
    int g;
    bit took;
    int acc;
    int chk;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      took = in_valid && in_ready;
      g    = gap_left;
      if (took) begin
        list_apply(in_req);
        accepted_n <= accepted_n + 1;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        g = tx_burst ? 0 : $urandom_range(0, 10);
      end
      if (!in_valid || took) begin
        acc = accepted_n + int'(took);
        chk = checked_n + int'(out_valid && out_ready);
        if (g > 0) begin
          in_valid <= 1'b0;
          g--;
        end else if (req_backlog.size() > 0 && (!req_backlog[0].drain || acc == chk)) begin
          in_valid <= 1'b1;
          in_req   <= req_backlog[0].req;
          void'(req_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      gap_left <= g;
    end
  end

  always @(posedge clk) begin : check_results
    pal_pkg::out_rsp_t want;
    int                n;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          $error("unexpected response: status %0d count %0d", out_rsp.status, out_rsp.count);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (out_rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp.status);
            errors++;
          end
          if (out_rsp.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, out_rsp.found_position);
            errors++;
          end
          if (out_rsp.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_rsp.read_value);
            errors++;
          end
          if (out_rsp.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_rsp.count);
            errors++;
          end
        end
        checked_n <= checked_n + 1;
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        n = rx_burst ? 0 : $urandom_range(0, 10);
        stall_left <= n;
        out_ready  <= (n == 0) && !rx_hold;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= (stall_left == 1) && !rx_hold;
      end else begin
        out_ready <= !rx_hold;
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold <= 1'b0;
    end else if (!hold_done && !rx_hold && accepted_n >= HOLD_AT) begin
      rx_hold  <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
    end else if (rx_hold) begin
      if (hold_cnt == 1) begin
        rx_hold   <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int       kind;
    int       op;
    int       pos;
    bit       bad;
    bit       first;
    bit       drain;
    logic [2:0] act;

    // directed: empty list, bad positions, extremes, every action
    push_req(pal_pkg::ACT_SEARCH, 0, 32'sd5, 1'b0);
    push_req(pal_pkg::ACT_READ, 1, 32'sd0, 1'b0);
    push_req(pal_pkg::ACT_DELETE, 1, 32'sd0, 1'b0);
    push_req(pal_pkg::ACT_INSERT, 0, 32'sd9, 1'b0);
    push_req(pal_pkg::ACT_INSERT, 2, 32'sd9, 1'b0);
    push_req(pal_pkg::ACT_INSERT, 1, 32'sh7FFFFFFF, 1'b0);
    push_req(pal_pkg::ACT_INSERT, 2, 32'sh80000000, 1'b0);
    push_req(pal_pkg::ACT_INSERT, 1, 32'sd0, 1'b0);
    push_req(pal_pkg::ACT_INSERT, 2, -32'sd1, 1'b0);
    push_req(pal_pkg::ACT_INSERT, 127, 32'sd3, 1'b0);
    for (int i = 1; i <= 4; i++) push_req(pal_pkg::ACT_READ, i, 32'sd0, 1'b0);
    push_req(pal_pkg::ACT_READ, 5, 32'sd0, 1'b0);
    push_req(pal_pkg::ACT_READ, 0, 32'sd0, 1'b0);
    push_req(pal_pkg::ACT_SEARCH, 0, 32'sh80000000, 1'b0);
    push_req(pal_pkg::ACT_SEARCH, 0, -32'sd1, 1'b0);
    push_req(pal_pkg::ACT_SEARCH, 0, 32'sd12345, 1'b0);
    push_req(pal_pkg::ACT_DELETE, 0, 32'sd0, 1'b0);
    push_req(pal_pkg::ACT_DELETE, 5, 32'sd0, 1'b0);
    push_req(pal_pkg::ACT_DELETE, 2, 32'sd0, 1'b0);
    push_req(pal_pkg::ACT_DELETE, 3, 32'sd0, 1'b0);
    push_req(3'd5, 1, 32'sd1, 1'b0);
    push_req(3'd6, 1, 32'sd1, 1'b0);
    push_req(3'd7, 1, 32'sd1, 1'b0);
    push_req(pal_pkg::ACT_CLEAR, 0, 32'sd0, 1'b0);

    first = 1'b1;
    while (gen_n < ITEMS_TOTAL) begin
      kind  = first ? 0 : $urandom_range(0, 99);
      first = 1'b0;
      if (kind < 6) begin
        // fill to the top by appending, then knock on a full list
        while (gen_len < DEPTH)
          push_req(pal_pkg::ACT_INSERT, gen_len + 1, pool_value(), 1'b0);
        repeat ($urandom_range(1, 3)) push_req(pal_pkg::ACT_INSERT, $urandom_range(0, 127),
                                               pool_value(), 1'b0);
        push_req(pal_pkg::ACT_SEARCH, 0, pool_value(), 1'b1);
      end else if (kind < 10) begin
        push_req(pal_pkg::ACT_CLEAR, $urandom_range(0, 127), $urandom, 1'b0);
      end else if (kind < 17) begin
        act = 3'($urandom_range(0, 7));
        push_req(act, $urandom_range(0, 127), $urandom, 1'b0);
      end else begin
        op    = $urandom_range(0, 99);
        bad   = ($urandom_range(0, 9) == 0);
        drain = ($urandom_range(0, 49) == 0);
        if (op < 35) begin
          pos = bad ? $urandom_range(0, 127) : $urandom_range(1, gen_len + 1);
          push_req(pal_pkg::ACT_INSERT, pos, pool_value(), drain);
        end else if (op < 55) begin
          pos = bad ? $urandom_range(0, 127) : $urandom_range(1, (gen_len > 0) ? gen_len : 1);
          push_req(pal_pkg::ACT_DELETE, pos, $urandom, drain);
        end else if (op < 80) begin
          push_req(pal_pkg::ACT_SEARCH, $urandom_range(0, 127),
                   ($urandom_range(0, 9) < 7) ? pool_value() : 32'($urandom), drain);
        end else begin
          pos = bad ? $urandom_range(0, 127) : $urandom_range(1, (gen_len > 0) ? gen_len : 1);
          push_req(pal_pkg::ACT_READ, pos, $urandom, drain);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || in_valid || accepted_n != checked_n) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
